/* hw/rtl/sek_pkg.sv */
// Shared types and constants for the squared-exponential kernel engine.
package sek_pkg;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_ACC,
    OP_TLO,
    OP_THI,
    OP_TSUM,
    OP_RED,
    OP_DIVN,
    OP_TMUL,
    OP_TDIV,
    OP_TADD,
    OP_CLAMP,
    OP_AMP,
    OP_SCALE,
    OP_SHIFT,
    OP_NOISE,
    OP_OUT
  } sek_op_t;

  typedef struct packed {
    sek_op_t op;
  } sek_cmd_t;

  typedef struct packed {
    logic last;      // captured coordinate pair is the last one
    logic t_big;     // scaled distance beyond the exp cutoff
    logic n_done;    // final step of the ln2 reduction
    logic dig_done;  // final digit of the term division
    logic k_done;    // final Taylor term
  } sek_sts_t;

  typedef struct packed {
    logic [15:0] signal_amplitude;
    logic [23:0] inv_two_len_sq;
    logic [15:0] noise_amplitude;
    logic        noise_enable;
  } sek_cfg_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SIGNAL_AMP = 2'd0;
  localparam logic [1:0] REG_INV_LEN    = 2'd1;
  localparam logic [1:0] REG_NOISE_AMP  = 2'd2;
  localparam logic [1:0] REG_NOISE_EN   = 2'd3;

  localparam logic [39:0] SUM_MAX      = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
  localparam logic [63:0] T_LIMIT      = 64'h0000_0030_0000_0000;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd10;
  localparam logic [2:0]  LN2_STEPS    = 3'd6;
  localparam logic [2:0]  DIG_STEPS    = 3'd7;

endpackage

/* hw/rtl/sek_ctrl.sv */
// Sequencing controller for the squared-exponential kernel engine.
module sek_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  sek_pkg::sek_sts_t sts,
  output sek_pkg::sek_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ACC, S_TLO, S_THI, S_TSUM, S_RED, S_DIVN, S_TMUL,
    S_TDIV, S_TADD, S_CLAMP, S_AMP, S_SCALE, S_SHIFT, S_NOISE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = sek_pkg::OP_NONE;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = sek_pkg::OP_LOAD;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op    = sek_pkg::OP_SQ;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = sek_pkg::OP_ACC;
        state_nxt = sts.last ? S_TLO : S_IDLE;
      end
      S_TLO: begin
        cmd.op    = sek_pkg::OP_TLO;
        state_nxt = S_THI;
      end
      S_THI: begin
        cmd.op    = sek_pkg::OP_THI;
        state_nxt = S_TSUM;
      end
      S_TSUM: begin
        cmd.op    = sek_pkg::OP_TSUM;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.op    = sek_pkg::OP_RED;
        state_nxt = sts.t_big ? S_SHIFT : S_DIVN;
      end
      S_DIVN: begin
        cmd.op = sek_pkg::OP_DIVN;
        if (sts.n_done) state_nxt = S_TMUL;
      end
      S_TMUL: begin
        cmd.op    = sek_pkg::OP_TMUL;
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        cmd.op = sek_pkg::OP_TDIV;
        if (sts.dig_done) state_nxt = S_TADD;
      end
      S_TADD: begin
        cmd.op    = sek_pkg::OP_TADD;
        state_nxt = sts.k_done ? S_CLAMP : S_TMUL;
      end
      S_CLAMP: begin
        cmd.op    = sek_pkg::OP_CLAMP;
        state_nxt = S_AMP;
      end
      S_AMP: begin
        cmd.op    = sek_pkg::OP_AMP;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = sek_pkg::OP_SCALE;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op    = sek_pkg::OP_SHIFT;
        state_nxt = S_NOISE;
      end
      S_NOISE: begin
        cmd.op    = sek_pkg::OP_NOISE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.op    = sek_pkg::OP_OUT;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready_nxt  = (state_nxt == S_IDLE);
  assign out_valid_nxt = out_load | (out_valid_r & ~out_tready);

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = in_ready_r;
  assign out_tvalid = out_valid_r;

endmodule

/* hw/rtl/sek_dp.sv */
// Arithmetic datapath: distance accumulator, shared multiplier, exp unit, output register.
module sek_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sek_pkg::sek_cmd_t cmd,
  output sek_pkg::sek_sts_t sts,
  input  sek_pkg::sek_cfg_t cfg,
  input  logic [15:0]       coord_a,
  input  logic [15:0]       coord_b,
  input  logic [9:0]        row_index,
  input  logic [9:0]        col_index,
  input  logic              last_coord,
  output logic [31:0]       kernel_value,
  output logic [9:0]        out_row,
  output logic [9:0]        out_col,
  output logic              saturated
);

  logic [15:0]        a_r, b_r;
  logic [9:0]         row_r, col_r;
  logic               last_r;
  logic [63:0]        mul_r;
  logic [39:0]        sum_r;
  logic [63:0]        t_r;
  logic               zero_r;
  logic [37:0]        rem_r;
  logic [6:0]         n_r;
  logic [2:0]         ncnt_r;
  logic [32:0]        term_r;
  logic [3:0]         k_r;
  logic [3:0]         dig_r;
  logic [2:0]         dcnt_r;
  logic signed [34:0] acc_r;
  logic [32:0]        e_r;
  logic [31:0]        kern_r;
  logic [31:0]        okern_r;
  logic [9:0]         orow_r, ocol_r;
  logic               osat_r;

  logic [16:0] diff, mag_full;
  logic [15:0] mag;
  logic [31:0] mul_a, mul_b;
  logic        mul_one;
  logic [63:0] product;
  logic [40:0] sum_w;
  logic [37:0] ln2_sh;
  logic [4:0]  part;
  logic [3:0]  qd;
  logic [3:0]  dig_w;
  logic [31:0] quo;
  logic signed [34:0] quo_s;
  logic [32:0] total;
  logic        diag_noise;

  // Absolute coordinate difference
  always_comb begin
    diff     = {a_r[15], a_r} - {b_r[15], b_r};
    mag_full = diff[16] ? (17'd0 - diff) : diff;
    mag      = mag_full[15:0];
  end

  // Operand select for the shared 32x32 multiplier; a one in bit 32 shifts instead
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_one = 1'b0;
    case (cmd.op)
      sek_pkg::OP_SQ: begin
        mul_a = {16'd0, mag};
        mul_b = {16'd0, mag};
      end
      sek_pkg::OP_TLO: begin
        mul_a = sum_r[31:0];
        mul_b = {8'd0, cfg.inv_two_len_sq};
      end
      sek_pkg::OP_THI: begin
        mul_a = {24'd0, sum_r[39:32]};
        mul_b = {8'd0, cfg.inv_two_len_sq};
      end
      sek_pkg::OP_TMUL: begin
        mul_a   = rem_r[31:0];
        mul_b   = term_r[31:0];
        mul_one = term_r[32];
      end
      sek_pkg::OP_AMP: begin
        mul_a = {16'd0, cfg.signal_amplitude};
        mul_b = {16'd0, cfg.signal_amplitude};
      end
      sek_pkg::OP_SCALE: begin
        mul_a   = mul_r[31:0];
        mul_b   = e_r[31:0];
        mul_one = e_r[32];
      end
      sek_pkg::OP_NOISE: begin
        mul_a = {16'd0, cfg.noise_amplitude};
        mul_b = {16'd0, cfg.noise_amplitude};
      end
      default: begin
        mul_a = '0;
      end
    endcase
    product = mul_one ? {mul_a, 32'd0} : (mul_a * mul_b);
  end

  // Saturating accumulate and ln2 reduction step
  always_comb begin
    sum_w  = {1'b0, sum_r} + {9'd0, mul_r[31:0]};
    ln2_sh = {6'd0, sek_pkg::LN2_Q32} << ncnt_r;
  end

  function automatic logic [3:0] dig_w_bit(input logic [4:0] p, input int idx);
    dig_w_bit = (idx == 0) ? dig_r : p[3:0];
  endfunction

  // Four quotient bits of the Taylor term division per cycle
  always_comb begin
    part = '0;
    qd   = '0;
    for (int i = 0; i < 4; i++) begin
      part = {dig_w_bit(part, i), mul_r[63 - i]};
      if (part >= {1'b0, k_r}) begin
        part      = part - {1'b0, k_r};
        qd[3 - i] = 1'b1;
      end
    end
    dig_w = part[3:0];
  end

  // Series update and final sum
  always_comb begin
    quo        = mul_r[63:32];
    quo_s      = $signed({3'd0, quo});
    diag_noise = cfg.noise_enable && (row_r == col_r);
    total      = {1'b0, kern_r} + (diag_noise ? {1'b0, mul_r[31:0]} : 33'd0);
  end

  // Accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.op == sek_pkg::OP_ACC) begin
      sum_r <= sum_w[40] ? sek_pkg::SUM_MAX : sum_w[39:0];
    end else if (cmd.op == sek_pkg::OP_TSUM) begin
      sum_r <= '0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      sek_pkg::OP_LOAD: begin
        a_r    <= coord_a;
        b_r    <= coord_b;
        row_r  <= row_index;
        col_r  <= col_index;
        last_r <= last_coord;
      end
      sek_pkg::OP_SQ, sek_pkg::OP_TLO, sek_pkg::OP_AMP,
      sek_pkg::OP_SCALE, sek_pkg::OP_NOISE: begin
        mul_r <= product;
      end
      sek_pkg::OP_THI: begin
        mul_r <= product;
        t_r   <= {8'd0, mul_r[55:0]};
      end
      sek_pkg::OP_TSUM: begin
        t_r <= t_r + {mul_r[31:0], 32'd0};
      end
      sek_pkg::OP_RED: begin
        zero_r <= (t_r >= sek_pkg::T_LIMIT);
        rem_r  <= t_r[37:0];
        n_r    <= '0;
        ncnt_r <= sek_pkg::LN2_STEPS;
        term_r <= {1'b1, 32'd0};
        acc_r  <= 35'sd4294967296;
        k_r    <= 4'd1;
      end
      sek_pkg::OP_DIVN: begin
        if (rem_r >= ln2_sh) begin
          rem_r          <= rem_r - ln2_sh;
          n_r[ncnt_r]    <= 1'b1;
        end
        ncnt_r <= ncnt_r - 3'd1;
      end
      sek_pkg::OP_TMUL: begin
        mul_r  <= product;
        dig_r  <= '0;
        dcnt_r <= '0;
      end
      sek_pkg::OP_TDIV: begin
        // shift dividend out at the top, quotient digits in at the bottom
        mul_r[63:32] <= {mul_r[59:32], qd};
        dig_r        <= dig_w;
        dcnt_r       <= dcnt_r + 3'd1;
      end
      sek_pkg::OP_TADD: begin
        term_r <= {1'b0, quo};
        acc_r  <= k_r[0] ? (acc_r - quo_s) : (acc_r + quo_s);
        k_r    <= k_r + 4'd1;
      end
      sek_pkg::OP_CLAMP: begin
        if (acc_r < 35'sd0) begin
          e_r <= '0;
        end else if (acc_r > 35'sd4294967296) begin
          e_r <= {1'b1, 32'd0};
        end else begin
          e_r <= acc_r[32:0];
        end
      end
      sek_pkg::OP_SHIFT: begin
        if (zero_r || n_r[6:5] != 2'd0) begin
          kern_r <= '0;
        end else begin
          kern_r <= mul_r[63:32] >> n_r[4:0];
        end
      end
      sek_pkg::OP_OUT: begin
        okern_r <= total[32] ? 32'hFFFF_FFFF : total[31:0];
        osat_r  <= total[32];
        orow_r  <= row_r;
        ocol_r  <= col_r;
      end
      default: begin
        last_r <= last_r;
      end
    endcase
  end

  assign sts.last     = last_r;
  assign sts.t_big    = (t_r >= sek_pkg::T_LIMIT);
  assign sts.n_done   = (ncnt_r == 3'd0);
  assign sts.dig_done = (dcnt_r == sek_pkg::DIG_STEPS);
  assign sts.k_done   = (k_r == sek_pkg::TAYLOR_TERMS);

  assign kernel_value = okern_r;
  assign out_row      = orow_r;
  assign out_col      = ocol_r;
  assign saturated    = osat_r;

endmodule

/* hw/rtl/squared_exp_kernel_engine.sv */
// Top level of the squared-exponential kernel engine: register port, controller, datapath.
// Each request carries one coordinate pair; the engine adds the squared difference to a
// 40-bit distance sum and, on the last coordinate, returns amp^2*exp(-sum*inv_two_len_sq)
// in Q16.16, plus noise^2 on the diagonal when enabled, saturated at all ones. A coordinate
// that is not last passes through accept, square and accumulate steps. For a last
// coordinate, the ln2 range reduction then runs 7 compare-subtract steps, and each of the
// 10 Taylor terms takes one pass through the shared 32x32 multiplier and a 4-bit-per-cycle
// divider; when the scaled distance is past the exp cutoff the reduction and the series are
// skipped. A finished result sits in the output register while the next coordinate is
// taken in.
module squared_exp_kernel_engine (
  input  logic        clk,
  input  logic        rst_n,
  // stream input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // coord_a[15:0], coord_b[31:16], row_index[41:32],
                                  // col_index[51:42], zero pad [55:52]
  input  logic        in_tlast,   // last_coord
  // stream output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // kernel_value[31:0], out_row[41:32], out_col[51:42],
                                  // zero pad [55:52]
  output logic [0:0]  out_tuser,  // saturated[0]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sek_pkg::sek_cfg_t cfg_r;
  sek_pkg::sek_cmd_t cmd;
  sek_pkg::sek_sts_t sts;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic [31:0]       kernel_value;
  logic [9:0]        out_row, out_col;
  logic              saturated;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.signal_amplitude <= 16'd256;
      cfg_r.inv_two_len_sq   <= 24'd32768;
      cfg_r.noise_amplitude  <= 16'd0;
      cfg_r.noise_enable     <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        sek_pkg::REG_SIGNAL_AMP: cfg_r.signal_amplitude <= pwdata[15:0];
        sek_pkg::REG_INV_LEN:    cfg_r.inv_two_len_sq   <= pwdata[23:0];
        sek_pkg::REG_NOISE_AMP:  cfg_r.noise_amplitude  <= pwdata[15:0];
        sek_pkg::REG_NOISE_EN:   cfg_r.noise_enable     <= pwdata[0];
        default:                 cfg_r.noise_enable     <= cfg_r.noise_enable;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      sek_pkg::REG_SIGNAL_AMP: prdata = {16'd0, cfg_r.signal_amplitude};
      sek_pkg::REG_INV_LEN:    prdata = {8'd0, cfg_r.inv_two_len_sq};
      sek_pkg::REG_NOISE_AMP:  prdata = {16'd0, cfg_r.noise_amplitude};
      sek_pkg::REG_NOISE_EN:   prdata = {31'd0, cfg_r.noise_enable};
      default:                 prdata = '0;
    endcase
  end

  sek_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  sek_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg_r),
    .coord_a      (in_tdata[15:0]),
    .coord_b      (in_tdata[31:16]),
    .row_index    (in_tdata[41:32]),
    .col_index    (in_tdata[51:42]),
    .last_coord   (in_tlast),
    .kernel_value (kernel_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .saturated    (saturated)
  );

  assign out_tdata = {4'd0, out_col, out_row, kernel_value};
  assign out_tuser = saturated;

  // A clipped result reads as all ones
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("saturated result not at maximum");

  // Only the noise term can push past the maximum, so clipping is on the diagonal
  a_sat_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[41:32] == out_tdata[51:42])
    else $error("saturation off the diagonal");

  // An accepted coordinate is worked on before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

endmodule
